// File: hw/rtl/sha256_message_hasher_top_macros.svh
// ----------------------------------------------------------------------------
// SHA-256 message hasher assertion macros
// Concurrent assertion wrappers that can be compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef SHA256_MESSAGE_HASHER_TOP_MACROS_SVH
`define SHA256_MESSAGE_HASHER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define SHA_ASSERT_SAME(label, clk, rstn, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
    else $error("sha256 hasher assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SHA_ASSERT_NEXT(label, clk, rstn, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
    else $error("sha256 hasher assertion failed");

`else

`define SHA_ASSERT_SAME(label, clk, rstn, pre, post)
`define SHA_ASSERT_NEXT(label, clk, rstn, pre, post)

`endif

`endif

// File: hw/rtl/sha256mh_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 message hasher package
// Round constants, initial hash values and the controller/datapath interface.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sha256mh_pkg;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] PAD_MARK = 32'h80000000;

  // Source of a word pushed into the block buffer.
  localparam logic [2:0] SRC_IN_FULL = 3'd0;  // input word, all four bytes
  localparam logic [2:0] SRC_IN_PAD  = 3'd1;  // short last word with marker byte
  localparam logic [2:0] SRC_MARK    = 3'd2;  // marker word after a full last word
  localparam logic [2:0] SRC_ZERO    = 3'd3;
  localparam logic [2:0] SRC_LEN_HI  = 3'd4;
  localparam logic [2:0] SRC_LEN_LO  = 3'd5;

  localparam logic [3:0] POS_LEN_HI = 4'd14;
  localparam logic [3:0] POS_FULL   = 4'd15;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [2:0] OUT_LAST   = 3'd7;

  typedef struct packed {
    logic       push;   // shift one word into the block buffer
    logic [2:0] src;    // which word to push
    logic       round;  // run one compression round
    logic [5:0] rnd;    // round index
    logic       fold;   // add working variables into the hash state
    logic       emit;   // shift out one digest word
    logic [2:0] cnt;    // digest word index
    logic       clear;  // return length and position to their reset values
  } cmd_t;

  typedef struct packed {
    logic [3:0] pos;    // next free block word
  } stat_t;

endpackage

// File: hw/rtl/sha256mh_datapath.sv
// ----------------------------------------------------------------------------
// SHA-256 message hasher datapath
// Block buffer and message schedule, round logic, hash state and bit length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha256mh_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sha256mh_pkg::cmd_t  cmd_i,
  input  logic [31:0]         msg_word_i,
  input  logic [2:0]          valid_bytes_i,
  output sha256mh_pkg::stat_t stat_o,
  output logic [31:0]         digest_word_o
);

  logic [31:0] hash_q  [8];
  logic [31:0] work_q  [8];
  logic [31:0] sched_q [16];
  logic [3:0]  pos_q;
  logic [63:0] bit_len_q;
  logic [63:0] bit_len_d;

  logic [31:0] push_word;
  logic [31:0] sched_new;
  logic [31:0] t1;
  logic [31:0] t2;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  // The short last word keeps its leading bytes and gets the marker byte after them.
  always_comb begin
    case (cmd_i.src)
      sha256mh_pkg::SRC_IN_FULL: push_word = msg_word_i;
      sha256mh_pkg::SRC_IN_PAD: begin
        case (valid_bytes_i[1:0])
          2'd0:    push_word = sha256mh_pkg::PAD_MARK;
          2'd1:    push_word = {msg_word_i[31:24], 24'h800000};
          2'd2:    push_word = {msg_word_i[31:16], 16'h8000};
          default: push_word = {msg_word_i[31:8], 8'h80};
        endcase
      end
      sha256mh_pkg::SRC_MARK:   push_word = sha256mh_pkg::PAD_MARK;
      sha256mh_pkg::SRC_LEN_HI: push_word = bit_len_q[63:32];
      sha256mh_pkg::SRC_LEN_LO: push_word = bit_len_q[31:0];
      default:                  push_word = '0;
    endcase
  end

  always_comb begin
    bit_len_d = bit_len_q;
    if (cmd_i.clear) begin
      bit_len_d = '0;
    end else if (cmd_i.push && (cmd_i.src == sha256mh_pkg::SRC_IN_FULL)) begin
      bit_len_d = bit_len_q + 64'd32;
    end else if (cmd_i.push && (cmd_i.src == sha256mh_pkg::SRC_IN_PAD)) begin
      bit_len_d = bit_len_q + {59'd0, valid_bytes_i[1:0], 3'd0};
    end
  end

  // sched_q[j] holds W[r+j] during round r.
  assign sched_new = (rotr(sched_q[14], 17) ^ rotr(sched_q[14], 19) ^ (sched_q[14] >> 10))
                   + sched_q[9]
                   + (rotr(sched_q[1], 7) ^ rotr(sched_q[1], 18) ^ (sched_q[1] >> 3))
                   + sched_q[0];

  assign t1 = work_q[7]
            + (rotr(work_q[4], 6) ^ rotr(work_q[4], 11) ^ rotr(work_q[4], 25))
            + ((work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]))
            + sha256mh_pkg::ROUND_K[cmd_i.rnd]
            + sched_q[0];

  assign t2 = (rotr(work_q[0], 2) ^ rotr(work_q[0], 13) ^ rotr(work_q[0], 22))
            + ((work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      bit_len_q <= '0;
    end else begin
      bit_len_q <= bit_len_d;
      if (cmd_i.clear) begin
        pos_q <= '0;
      end else if (cmd_i.push) begin
        pos_q <= pos_q + 4'd1;
      end
    end
  end

  // Digest words leave from hash_q[0]; the initial values shift in behind them.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        hash_q[i] <= sha256mh_pkg::INIT_HASH[i];
      end
    end else if (cmd_i.fold) begin
      for (int i = 0; i < 8; i++) begin
        hash_q[i] <= hash_q[i] + work_q[i];
      end
    end else if (cmd_i.emit) begin
      for (int i = 0; i < 7; i++) begin
        hash_q[i] <= hash_q[i+1];
      end
      hash_q[7] <= sha256mh_pkg::INIT_HASH[cmd_i.cnt];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push && (pos_q == sha256mh_pkg::POS_FULL)) begin
      for (int i = 0; i < 8; i++) begin
        work_q[i] <= hash_q[i];
      end
    end else if (cmd_i.round) begin
      work_q[7] <= work_q[6];
      work_q[6] <= work_q[5];
      work_q[5] <= work_q[4];
      work_q[4] <= work_q[3] + t1;
      work_q[3] <= work_q[2];
      work_q[2] <= work_q[1];
      work_q[1] <= work_q[0];
      work_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push || cmd_i.round) begin
      for (int i = 0; i < 15; i++) begin
        sched_q[i] <= sched_q[i+1];
      end
      sched_q[15] <= cmd_i.push ? push_word : sched_new;
    end
  end

  assign stat_o.pos    = pos_q;
  assign digest_word_o = hash_q[0];

endmodule

// File: hw/rtl/sha256mh_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-256 message hasher controller
// Sequences word intake, padding, compression rounds and digest output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha256mh_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_last_i,
  input  logic [2:0]          valid_bytes_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                out_last_o,
  input  sha256mh_pkg::stat_t stat_i,
  output sha256mh_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_FOLD  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [5:0] rnd_q, rnd_d;
  logic [2:0] cnt_q, cnt_d;
  logic       padding_q, padding_d;
  logic       mark_q, mark_d;
  logic       hi_q, hi_d;
  logic       final_q, final_d;
  logic       block_full;

  assign block_full = (stat_i.pos == sha256mh_pkg::POS_FULL);

  always_comb begin
    state_d   = state_q;
    rnd_d     = rnd_q;
    cnt_d     = cnt_q;
    padding_d = padding_q;
    mark_d    = mark_q;
    hi_d      = hi_q;
    final_d   = final_q;
    cmd_o       = '0;
    cmd_o.rnd   = rnd_q;
    cmd_o.cnt   = cnt_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    out_last_o  = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.push = 1'b1;
          // A count of four or more on the last word means a full word.
          if (in_last_i && !valid_bytes_i[2]) begin
            cmd_o.src = sha256mh_pkg::SRC_IN_PAD;
          end else begin
            cmd_o.src = sha256mh_pkg::SRC_IN_FULL;
          end
          if (in_last_i) begin
            padding_d = 1'b1;
            mark_d    = valid_bytes_i[2];
          end
          if (block_full) begin
            rnd_d   = '0;
            state_d = S_ROUND;
          end else if (in_last_i) begin
            state_d = S_PAD;
          end
        end
      end

      S_PAD: begin
        cmd_o.push = 1'b1;
        if (mark_q) begin
          cmd_o.src = sha256mh_pkg::SRC_MARK;
          mark_d    = 1'b0;
        end else if (stat_i.pos == sha256mh_pkg::POS_LEN_HI) begin
          cmd_o.src = sha256mh_pkg::SRC_LEN_HI;
          hi_d      = 1'b1;
        end else if (block_full && hi_q) begin
          cmd_o.src = sha256mh_pkg::SRC_LEN_LO;
          final_d   = 1'b1;
        end else begin
          cmd_o.src = sha256mh_pkg::SRC_ZERO;
        end
        if (block_full) begin
          rnd_d   = '0;
          state_d = S_ROUND;
        end
      end

      S_ROUND: begin
        cmd_o.round = 1'b1;
        rnd_d       = rnd_q + 6'd1;
        if (rnd_q == sha256mh_pkg::ROUND_LAST) begin
          state_d = S_FOLD;
        end
      end

      S_FOLD: begin
        cmd_o.fold = 1'b1;
        if (final_q) begin
          cnt_d   = '0;
          state_d = S_EMIT;
        end else if (padding_q) begin
          state_d = S_PAD;
        end else begin
          state_d = S_IDLE;
        end
      end

      S_EMIT: begin
        out_valid_o = 1'b1;
        out_last_o  = (cnt_q == sha256mh_pkg::OUT_LAST);
        if (out_ready_i) begin
          cmd_o.emit = 1'b1;
          cnt_d      = cnt_q + 3'd1;
          if (cnt_q == sha256mh_pkg::OUT_LAST) begin
            cmd_o.clear = 1'b1;
            padding_d   = 1'b0;
            mark_d      = 1'b0;
            hi_d        = 1'b0;
            final_d     = 1'b0;
            state_d     = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rnd_q     <= '0;
      cnt_q     <= '0;
      padding_q <= 1'b0;
      mark_q    <= 1'b0;
      hi_q      <= 1'b0;
      final_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      rnd_q     <= rnd_d;
      cnt_q     <= cnt_d;
      padding_q <= padding_d;
      mark_q    <= mark_d;
      hi_q      <= hi_d;
      final_q   <= final_d;
    end
  end

endmodule

// File: hw/rtl/sha256_message_hasher_top.sv
// The hasher takes a message as big-endian 32-bit words, one per cycle while it is
// ready, and returns the SHA-256 digest as eight words, A first, the eighth marked
// with tlast. Every sixteenth word starts a compression of 64 rounds, one round
// per cycle, after which a fold adds the result into the hash state. The single
// round unit limits the throughput. On the last word the padding words are
// pushed at one per cycle (up to 18, with one or two compressions) before the
// digest appears; after the eighth digest transaction the block is back in its
// initial state and takes the next message.
// ----------------------------------------------------------------------------
// SHA-256 message hasher top level
// Streaming SHA-256 engine built from a controller and a datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sha256_message_hasher_top_macros.svh"

module sha256_message_hasher_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // [31:0] message_word, [34:32] valid_bytes, rest zero
  input  logic        s_axis_tlast_i,   // is_last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] digest_word
  output logic        m_axis_tlast_o    // digest_last
);

  sha256mh_pkg::cmd_t  cmd;
  sha256mh_pkg::stat_t stat;

  sha256mh_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_last_i     (s_axis_tlast_i),
    .valid_bytes_i (s_axis_tdata_i[34:32]),
    .in_ready_o    (s_axis_tready_o),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_last_o    (m_axis_tlast_o),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  sha256mh_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .msg_word_i    (s_axis_tdata_i[31:0]),
    .valid_bytes_i (s_axis_tdata_i[34:32]),
    .stat_o        (stat),
    .digest_word_o (m_axis_tdata_o)
  );

  // Intake and digest output never overlap.
  `SHA_ASSERT_SAME(a_no_overlap, clk_i, rst_ni, m_axis_tvalid_o, !s_axis_tready_o)

  // A push that fills the block starts the rounds at round zero.
  `SHA_ASSERT_NEXT(a_full_starts_rounds, clk_i, rst_ni,
                   cmd.push && (stat.pos == sha256mh_pkg::POS_FULL),
                   cmd.round && (cmd.rnd == 6'd0))

  // The last round is followed by the fold into the hash state.
  `SHA_ASSERT_NEXT(a_fold_after_rounds, clk_i, rst_ni,
                   cmd.round && (cmd.rnd == sha256mh_pkg::ROUND_LAST), cmd.fold)

  // After the final digest word the block is ready with an empty buffer.
  `SHA_ASSERT_NEXT(a_clean_restart, clk_i, rst_ni,
                   m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o,
                   s_axis_tready_o && (stat.pos == 4'd0))

endmodule
